[src/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ASSERT_AT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("assertion failed");

// Check that post holds in the cycle after pre.
`define ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) else $error("assertion failed");

`endif

[src/rcr_pkg.sv]
package rcr_pkg;

  localparam int COEF_WIDTH_DEF = 61;
  localparam int LANES          = 3;
  localparam int RED_LANES      = 2 * LANES + 1;
  localparam int INV_LANE       = 2 * LANES;
  localparam int CFG_INDEX_W    = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL_MODULUS = 2'd0,
    REG_TOP_MODULUS   = 2'd1,
    REG_TOP_INVERSE   = 2'd2,
    REG_THREE_PARTS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic advance;
    logic small_mod;
  } pipe_ctl_t;

endpackage

[src/rns_coefficient_rescale_top.sv]
// RNS rescale of one coefficient position per beat for up to three ciphertext
// components: each component gives ((level - top) mod m) * top_inverse mod m with
// m = level_modulus. Fully pipelined: one beat is taken every cycle unless the
// output stalls, and each result passes through one stage per bit of the
// restoring reduction of the inputs and of top_inverse, one subtract stage, and
// one stage per bit of the double-and-add multiply. A stalled output holds the
// whole pipeline. scaled_c is zero unless three_parts is set, and all results
// are zero when level_modulus is below two.
// Registers may be written only while the pipeline is empty.
`include "assert_macros.svh"

module rns_coefficient_rescale_top
  import rcr_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // level_coef_a, level_coef_b, level_coef_c, top_coef_a, top_coef_b, top_coef_c
  input  logic [((6*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // scaled_a, scaled_b, scaled_c
  output logic [((3*COEF_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W        = COEF_WIDTH;
  localparam int OUT_BITS = LANES * W;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

  logic [W-1:0] level_modulus;
  logic [W-1:0] top_modulus;
  logic [W-1:0] top_inverse;
  logic         three_parts;

  pipe_ctl_t    ctl;
  logic [W-1:0] red_in [RED_LANES];
  logic [W-1:0] red_out [RED_LANES];
  logic         red_valid;
  logic         sub_valid;
  logic [W-1:0] sub_d [LANES];
  logic [W-1:0] sub_inv;
  logic [W-1:0] prod [LANES];
  logic         mul_valid;
  logic [OUT_BITS-1:0] out_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_modulus <= W'(2);
      top_modulus   <= W'(2);
      top_inverse   <= W'(1);
      three_parts   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEVEL_MODULUS: level_modulus <= cfg_data;
        REG_TOP_MODULUS:   top_modulus   <= cfg_data;
        REG_TOP_INVERSE:   top_inverse   <= cfg_data;
        REG_THREE_PARTS:   three_parts   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ctl.advance   = !m_axis_tvalid || m_axis_tready;
  assign ctl.small_mod = (level_modulus < W'(2)) || (top_modulus == '0 && 1'b0);
  assign s_axis_tready = ctl.advance;

  always_comb begin
    for (int i = 0; i < 2 * LANES; i++) begin
      red_in[i] = s_axis_tdata[i*W +: W];
    end
    red_in[INV_LANE] = top_inverse;
  end

  rcr_reduce #(.W(W), .NL(RED_LANES)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (s_axis_tvalid),
    .x         (red_in),
    .modulus   (level_modulus),
    .out_valid (red_valid),
    .res       (red_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_valid <= 1'b0;
    end else if (ctl.advance) begin
      sub_valid <= red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      sub_inv <= red_out[INV_LANE];
      for (int j = 0; j < LANES; j++) begin
        if (red_out[j] >= red_out[LANES+j]) begin
          sub_d[j] <= red_out[j] - red_out[LANES+j];
        end else begin
          sub_d[j] <= red_out[j] + (level_modulus - red_out[LANES+j]);
        end
      end
    end
  end

  rcr_mulmod #(.W(W), .NL(LANES)) u_mulmod (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (sub_valid),
    .a         (sub_d),
    .b         (sub_inv),
    .modulus   (level_modulus),
    .out_valid (mul_valid),
    .prod      (prod)
  );

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (ctl.small_mod || (j == LANES - 1 && !three_parts)) begin
        out_bits[j*W +: W] = '0;
      end else begin
        out_bits[j*W +: W] = prod[j];
      end
    end
  end

  assign m_axis_tvalid = mul_valid;
  assign m_axis_tdata  = OUT_TW'(out_bits);

  `ASSERT_AT(a_ready_follows_out, clk, rst,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `ASSERT_NEXT(a_sub_holds, clk, rst, sub_valid && !ctl.advance,
    sub_valid && $stable(sub_d[0]) && $stable(sub_inv))

endmodule

[src/rcr_reduce.sv]
`include "assert_macros.svh"

module rcr_reduce
  import rcr_pkg::*;
#(
  parameter int W  = COEF_WIDTH_DEF,
  parameter int NL = RED_LANES
) (
  input  logic         clk,
  input  logic         rst,
  input  pipe_ctl_t    ctl,
  input  logic         in_valid,
  input  logic [W-1:0] x [NL],
  input  logic [W-1:0] modulus,
  output logic         out_valid,
  output logic [W-1:0] res [NL]
);

  function automatic logic [W-1:0] red_step(input logic [W-1:0] r, input logic b,
                                            input logic [W-1:0] m);
    logic [W:0] s;
    s = {r, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [W-1:0] valid;
  logic [W-1:0] stg_x [W][NL];
  logic [W-1:0] stg_r [W][NL];
  logic         all_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.advance) begin
      valid <= {valid[W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int k = 0; k < W; k++) begin
        for (int i = 0; i < NL; i++) begin
          if (k == 0) begin
            stg_x[k][i] <= x[i];
            stg_r[k][i] <= red_step('0, x[i][W-1], modulus);
          end else begin
            stg_x[k][i] <= stg_x[k-1][i];
            stg_r[k][i] <= red_step(stg_r[k-1][i], stg_x[k-1][i][W-1-k], modulus);
          end
        end
      end
    end
  end

  always_comb begin
    all_below = 1'b1;
    for (int i = 0; i < NL; i++) begin
      res[i] = stg_r[W-1][i];
      if (stg_r[W-1][i] >= modulus) all_below = 1'b0;
    end
  end

  assign out_valid = valid[W-1];

  `ASSERT_AT(a_red_below, clk, rst, (out_valid && !ctl.small_mod) |-> all_below)

endmodule

[src/rcr_mulmod.sv]
`include "assert_macros.svh"

module rcr_mulmod
  import rcr_pkg::*;
#(
  parameter int W  = COEF_WIDTH_DEF,
  parameter int NL = LANES
) (
  input  logic         clk,
  input  logic         rst,
  input  pipe_ctl_t    ctl,
  input  logic         in_valid,
  input  logic [W-1:0] a [NL],
  input  logic [W-1:0] b,
  input  logic [W-1:0] modulus,
  output logic         out_valid,
  output logic [W-1:0] prod [NL]
);

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [W-1:0] valid;
  logic [W-1:0] stg_a [W][NL];
  logic [W-1:0] stg_b [W];
  logic [W-1:0] stg_r [W][NL];
  logic         all_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.advance) begin
      valid <= {valid[W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int k = 0; k < W; k++) begin
        if (k == 0) begin
          stg_b[k] <= b;
        end else begin
          stg_b[k] <= stg_b[k-1];
        end
        for (int i = 0; i < NL; i++) begin
          if (k == 0) begin
            stg_a[k][i] <= a[i];
            stg_r[k][i] <= b[W-1] ? add_mod('0, a[i], modulus) : '0;
          end else begin
            stg_a[k][i] <= stg_a[k-1][i];
            stg_r[k][i] <= stg_b[k-1][W-1-k]
                ? add_mod(add_mod(stg_r[k-1][i], stg_r[k-1][i], modulus),
                          stg_a[k-1][i], modulus)
                : add_mod(stg_r[k-1][i], stg_r[k-1][i], modulus);
          end
        end
      end
    end
  end

  always_comb begin
    all_below = 1'b1;
    for (int i = 0; i < NL; i++) begin
      prod[i] = stg_r[W-1][i];
      if (stg_r[W-1][i] >= modulus) all_below = 1'b0;
    end
  end

  assign out_valid = valid[W-1];

  `ASSERT_AT(a_mul_below, clk, rst, (out_valid && !ctl.small_mod) |-> all_below)

endmodule
